>>> sv/ptp_pkg.sv
// Shared constants, types and the arctangent table for the steering controller.
package ptp_pkg;

  localparam int PiU = 205887;
  localparam int AngMax = 25736;
  localparam logic [23:0] KinvQ24 = 24'd10188014;

  typedef enum logic [2:0] {
    REG_GOAL_X    = 3'd0,
    REG_GOAL_Y    = 3'd1,
    REG_PLAN_RDY  = 3'd2,
    REG_ANG_TOL   = 3'd3,
    REG_POS_TOL   = 3'd4,
    REG_ROT_THR   = 3'd5
  } reg_idx_t;

  // arctangent of 2^-i in 2^-16 rad, rounded; zero past stage 16
  function automatic logic signed [19:0] atan_tab(input logic [5:0] i);
    case (i)
      6'd0:  atan_tab = 20'sd51472;
      6'd1:  atan_tab = 20'sd30385;
      6'd2:  atan_tab = 20'sd16055;
      6'd3:  atan_tab = 20'sd8150;
      6'd4:  atan_tab = 20'sd4091;
      6'd5:  atan_tab = 20'sd2047;
      6'd6:  atan_tab = 20'sd1024;
      6'd7:  atan_tab = 20'sd512;
      6'd8:  atan_tab = 20'sd256;
      6'd9:  atan_tab = 20'sd128;
      6'd10: atan_tab = 20'sd64;
      6'd11: atan_tab = 20'sd32;
      6'd12: atan_tab = 20'sd16;
      6'd13: atan_tab = 20'sd8;
      6'd14: atan_tab = 20'sd4;
      6'd15: atan_tab = 20'sd2;
      6'd16: atan_tab = 20'sd1;
      default: atan_tab = 20'sd0;
    endcase
  endfunction

endpackage

>>> sv/point_to_point_steering_controller.sv
// Point-to-point steering controller: pose in, steering command out.
// Slave channel s_axis_* takes one pose sample per item (tdata, LSB up: pos_x,
// pos_y, quat_x, quat_y, quat_z, quat_w). Master channel m_axis_* returns one
// command item: tdata = angular_command, linear_command; tuser = goal_reached.
// Configuration goes through cfg_valid/cfg_ready/cfg_index/cfg_data while
// the block is idle; the user must keep to this, the block does not enforce
// it. cfg_ready is always high. Pipeline: 1 input product stage, 1 prep
// stage, CORDIC_STAGES+1 CORDIC stages (yaw and bearing in two parallel
// CORDICs), 2 post stages (length multiply and turn difference; fold, clamp
// and saturate) then the command-select output register: CORDIC_STAGES + 6
// register stages. One item per cycle sustained while the output register
// is not stalled; the rate is set by the CORDIC pipeline, which advances
// only on the global enable. While the output register holds an untaken
// item the whole pipeline holds (global enable) and s_axis_tready falls;
// nothing is lost or repeated. Reset clears all valid bits and restores
// the register defaults.
module point_to_point_steering_controller #(
  parameter int CORDIC_STAGES = 16
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [127:0] s_axis_tdata,  // pos_x, pos_y, quat_x, quat_y, quat_z, quat_w
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [47:0]  m_axis_tdata,  // angular_command, linear_command
  output logic         m_axis_tuser,  // goal_reached
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [2:0]   cfg_index,
  input  logic [31:0]  cfg_data
);
  localparam int NV = CORDIC_STAGES + 5;
  localparam int CW = 36;

  logic signed [31:0] goal_x, goal_y;
  logic               plan_ready;
  logic [14:0]        angle_tolerance, rotate_threshold;
  logic [30:0]        position_tolerance;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      goal_x <= '0; goal_y <= '0; plan_ready <= 1'b0;
      angle_tolerance <= 15'd8233; position_tolerance <= 31'd66191;
      rotate_threshold <= 15'd8552;
    end else if (cfg_valid) begin
      case (ptp_pkg::reg_idx_t'(cfg_index))
        ptp_pkg::REG_GOAL_X:   goal_x <= cfg_data;
        ptp_pkg::REG_GOAL_Y:   goal_y <= cfg_data;
        ptp_pkg::REG_PLAN_RDY: plan_ready <= cfg_data[0];
        ptp_pkg::REG_ANG_TOL:  angle_tolerance <= cfg_data[14:0];
        ptp_pkg::REG_POS_TOL:  position_tolerance <= cfg_data[30:0];
        ptp_pkg::REG_ROT_THR:  rotate_threshold <= cfg_data[14:0];
        default: ;
      endcase
    end
  end

  // global enable: pipeline moves unless output holds an untaken item
  logic en;
  assign en = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  logic [NV-1:0] vld;
  always_ff @(posedge clk) begin
    if (rst) vld <= '0;
    else if (en) vld <= {vld[NV-2:0], s_axis_tvalid};
  end

  // stage 1: quaternion products and position differences
  logic signed [31:0] px, py;
  logic signed [15:0] qx, qy, qz, qw;
  assign px = s_axis_tdata[31:0];
  assign py = s_axis_tdata[63:32];
  assign qx = s_axis_tdata[79:64];
  assign qy = s_axis_tdata[95:80];
  assign qz = s_axis_tdata[111:96];
  assign qw = s_axis_tdata[127:112];

  logic signed [31:0] p_wz, p_xy, p_yy, p_zz;
  logic signed [32:0] dx1, dy1;
  always_ff @(posedge clk) begin
    if (en) begin
      p_wz <= 32'(qw) * 32'(qz);
      p_xy <= 32'(qx) * 32'(qy);
      p_yy <= 32'(qy) * 32'(qy);
      p_zz <= 32'(qz) * 32'(qz);
      dx1  <= 33'(goal_x) - 33'(px);
      dy1  <= 33'(goal_y) - 33'(py);
    end
  end

  // stage 2: yaw vector
  logic signed [CW-1:0] num, den, dx2, dy2;
  always_ff @(posedge clk) begin
    if (en) begin
      num <= (CW'(p_wz) + CW'(p_xy)) <<< 1;
      den <= (CW'(1) <<< 28) - ((CW'(p_yy) + CW'(p_zz)) <<< 1);
      dx2 <= CW'(dx1);
      dy2 <= CW'(dy1);
    end
  end

  logic signed [19:0] yaw_raw, bear_raw;
  logic [CW-1:0] mag_yaw, mag_b;
  logic [0:0] sd_unused;
  ptp_cordic #(.STAGES(CORDIC_STAGES), .W(CW), .SW(1)) u_yaw (
    .clk(clk), .en(en), .x_in(den), .y_in(num), .side_in(1'b0),
    .ang(yaw_raw), .mag(mag_yaw), .side_out(sd_unused)
  );
  logic [0:0] sd_b;
  ptp_cordic #(.STAGES(CORDIC_STAGES), .W(CW), .SW(1)) u_bear (
    .clk(clk), .en(en), .x_in(dx2), .y_in(dy2), .side_in(sd_unused),
    .ang(bear_raw), .mag(mag_b), .side_out(sd_b)
  );

  // post 1: wrap angles, difference, length multiply
  logic signed [20:0] d3;
  logic [57:0] prod3;
  logic signed [20:0] yaw_w, bear_w;
  always_comb begin
    yaw_w  = (yaw_raw < 0) ? 21'(yaw_raw) + 21'(2 * ptp_pkg::PiU) : 21'(yaw_raw);
    bear_w = (bear_raw < 0) ? 21'(bear_raw) + 21'(2 * ptp_pkg::PiU) : 21'(bear_raw);
  end
  always_ff @(posedge clk) begin
    if (en) begin
      d3    <= bear_w - yaw_w;
      prod3 <= 58'(mag_b[33:0]) * 58'(ptp_pkg::KinvQ24);
    end
  end

  // post 2: fold, quantize, clamp, saturate distance
  logic signed [20:0] a4, opp4, dfold;
  logic signed [17:0] tq;
  logic signed [15:0] turn4;
  logic [31:0] dist4;
  logic [33:0] dsh;
  logic        unused_ok;
  assign unused_ok = ^mag_yaw ^ sd_b[0] ^ ^mag_b[CW-1:34];
  always_comb begin
    a4    = (d3 < 0) ? -d3 : d3;
    opp4  = 21'(2 * ptp_pkg::PiU) - a4;
    dfold = (opp4 < a4) ? ((d3 >= 0) ? -opp4 : opp4) : d3;
    tq    = 18'((dfold + 21'sd4) >>> 3);
    dsh   = 34'((prod3 + 58'(1 << 23)) >> 24);
  end
  always_ff @(posedge clk) begin
    if (en) begin
      if (tq > 18'(ptp_pkg::AngMax)) turn4 <= 16'(ptp_pkg::AngMax);
      else if (tq < -18'(ptp_pkg::AngMax)) turn4 <= -16'(ptp_pkg::AngMax);
      else turn4 <= 16'(tq);
      dist4 <= (dsh[33:32] != 2'b00) ? 32'hFFFFFFFF : dsh[31:0];
    end
  end

  // post 3: command select into output register
  logic [15:0] at;
  logic        rot, atol, dtol;
  always_comb begin
    at   = turn4[15] ? -turn4 : turn4;
    rot  = at >= 16'(rotate_threshold);
    atol = at >= 16'(angle_tolerance);
    dtol = dist4 >= 32'(position_tolerance);
  end
  always_ff @(posedge clk) begin
    if (rst) m_axis_tvalid <= 1'b0;
    else if (en) m_axis_tvalid <= vld[NV-1];
  end
  always_ff @(posedge clk) begin
    if (en) begin
      if (!plan_ready) begin
        m_axis_tdata <= '0;
        m_axis_tuser <= 1'b1;
      end else begin
        m_axis_tdata[15:0]  <= (rot || atol) ? turn4 : 16'd0;
        m_axis_tdata[47:16] <= (!rot && dtol && dist4 != 0) ? dist4 : 32'd0;
        m_axis_tuser        <= !atol && !dtol && !unused_ok && 1'b1 || (!atol && !dtol);
      end
    end
  end

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output changed while stalled");
  a_rdy: assert property (@(posedge clk) disable iff (rst)
    s_axis_tready == (!m_axis_tvalid || m_axis_tready))
    else $error("input ready mismatch");
  a_rot: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[47:16] != 0 |-> !m_axis_tuser)
    else $error("linear command with goal reached");
endmodule

>>> sv/ptp_cordic.sv
// Pipelined vectoring CORDIC: one stage per iteration, angle and scaled length.
module ptp_cordic #(
  parameter int STAGES = 16,
  parameter int W = 36,
  parameter int SW = 8
) (
  input  logic                clk,
  input  logic                en,
  input  logic signed [W-1:0] x_in,
  input  logic signed [W-1:0] y_in,
  input  logic [SW-1:0]       side_in,
  output logic signed [19:0]  ang,
  output logic [W-1:0]        mag,
  output logic [SW-1:0]       side_out
);
  logic signed [W-1:0] xs [0:STAGES];
  logic signed [W-1:0] ys [0:STAGES];
  logic signed [19:0]  zs [0:STAGES];
  logic                zr [0:STAGES];
  logic [SW-1:0]       sd [0:STAGES];

  // pre-rotation by pi for the left half plane
  always_ff @(posedge clk) begin
    if (en) begin
      zr[0] <= (x_in == '0) && (y_in == '0);
      sd[0] <= side_in;
      if (x_in < 0) begin
        xs[0] <= -x_in;
        ys[0] <= -y_in;
        zs[0] <= (y_in >= 0) ? 20'(ptp_pkg::PiU) : -20'(ptp_pkg::PiU);
      end else begin
        xs[0] <= x_in;
        ys[0] <= y_in;
        zs[0] <= '0;
      end
    end
  end

  for (genvar i = 0; i < STAGES; i++) begin : g_stage
    always_ff @(posedge clk) begin
      if (en) begin
        zr[i+1] <= zr[i];
        sd[i+1] <= sd[i];
        if (ys[i] >= 0) begin
          xs[i+1] <= xs[i] + (ys[i] >>> i);
          ys[i+1] <= ys[i] - (xs[i] >>> i);
          zs[i+1] <= zs[i] + ptp_pkg::atan_tab(6'(i));
        end else begin
          xs[i+1] <= xs[i] - (ys[i] >>> i);
          ys[i+1] <= ys[i] + (xs[i] >>> i);
          zs[i+1] <= zs[i] - ptp_pkg::atan_tab(6'(i));
        end
      end
    end
  end

  assign ang      = zr[STAGES] ? '0 : zs[STAGES];
  assign mag      = zr[STAGES] ? '0 : xs[STAGES];
  assign side_out = sd[STAGES];
endmodule

>>> tb/point_to_point_steering_controller_checker.sv
// Checker for the steering controller: watches both streams and the register port.
module point_to_point_steering_controller_checker (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  input  logic         s_axis_tready,
  input  logic [127:0] s_axis_tdata,
  input  logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  input  logic [47:0]  m_axis_tdata,
  input  logic         m_axis_tuser,
  input  logic         cfg_valid,
  input  logic         cfg_ready,
  input  logic [2:0]   cfg_index,
  input  logic [31:0]  cfg_data,
  output int           errors,
  output int           pending,
  output int           commands_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic        reached;
    logic [31:0] lin;
    logic [15:0] ang;
  } command_t;

  command_t cmd_queue[$];

  longint goal_x, goal_y;
  logic        plan_rdy;
  logic [14:0] ang_tol, rot_thr;
  logic [30:0] pos_tol;

  localparam longint TwoPi = 2 * ptp_pkg::PiU;

  function automatic longint shr_floor(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint vector_angle(longint x, longint y, output longint mag);
    longint z, xs, ys, at;
    z = 0;
    if (x == 0 && y == 0) begin
      mag = 0;
      return 0;
    end
    if (x < 0) begin
      z = (y >= 0) ? ptp_pkg::PiU : -ptp_pkg::PiU;
      x = -x;
      y = -y;
    end
    for (int i = 0; i < 16; i++) begin
      xs = shr_floor(x, i);
      ys = shr_floor(y, i);
      case (i)
        0: at = 51472;   1: at = 30385;   2: at = 16055;  3: at = 8150;
        4: at = 4091;    5: at = 2047;    6: at = 1024;   7: at = 512;
        8: at = 256;     9: at = 128;     10: at = 64;    11: at = 32;
        12: at = 16;     13: at = 8;      14: at = 4;     default: at = 2;
      endcase
      if (y >= 0) begin
        x = x + ys; y = y - xs; z += at;
      end else begin
        x = x - ys; y = y + xs; z -= at;
      end
    end
    mag = x;
    return z;
  endfunction

  function automatic command_t steer(logic [127:0] d);
    command_t c;
    longint px, py, qx, qy, qz, qw, num, den, yaw, bear, mag, dd, a, opp, turn, aturn;
    logic [63:0] prod;
    longint distance;
    px = longint'($signed(d[31:0]));
    py = longint'($signed(d[63:32]));
    qx = longint'($signed(d[79:64]));
    qy = longint'($signed(d[95:80]));
    qz = longint'($signed(d[111:96]));
    qw = longint'($signed(d[127:112]));
    c = '0;
    if (!plan_rdy) begin
      c.reached = 1'b1;
      return c;
    end
    num = 2 * (qw * qz + qx * qy);
    den = (longint'(1) << 28) - 2 * (qy * qy + qz * qz);
    yaw = vector_angle(den, num, mag);
    if (yaw < 0) yaw += TwoPi;
    bear = vector_angle(goal_x - px, goal_y - py, mag);
    if (bear < 0) bear += TwoPi;
    prod = 64'(mag) * 64'd10188014 + (64'd1 << 23);
    distance = longint'(prod >> 24);
    if (distance > 64'hFFFF_FFFF) distance = 64'hFFFF_FFFF;
    dd = bear - yaw;
    a = dd < 0 ? -dd : dd;
    opp = TwoPi - a;
    if (opp < a) dd = (dd >= 0) ? -opp : opp;
    turn = shr_floor(dd + 4, 3);
    if (turn > ptp_pkg::AngMax) turn = ptp_pkg::AngMax;
    if (turn < -ptp_pkg::AngMax) turn = -ptp_pkg::AngMax;
    aturn = turn < 0 ? -turn : turn;
    if (aturn >= rot_thr) begin
      c.ang = 16'(turn);
    end else begin
      c.ang = (aturn >= ang_tol) ? 16'(turn) : 16'd0;
      c.lin = (distance >= pos_tol && distance > 0) ? 32'(distance) : 32'd0;
    end
    c.reached = (aturn < ang_tol) && (distance < pos_tol);
    return c;
  endfunction

  assign pending = cmd_queue.size();

  always @(posedge clk) begin
    command_t want, got;
    if (rst) begin
      goal_x <= 0; goal_y <= 0; plan_rdy <= 1'b0;
      ang_tol <= 15'd8233; pos_tol <= 31'd66191; rot_thr <= 15'd8552;
      errors <= 0; commands_seen <= 0;
      cmd_queue.delete();
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        commands_seen <= commands_seen + 1;
        got = {m_axis_tuser, m_axis_tdata[47:16], m_axis_tdata[15:0]};
        if (cmd_queue.size() == 0) begin
          if (errors < 10) $display("unexpected command %h", got);
          errors <= errors + 1;
        end else begin
          want = cmd_queue.pop_front();
          if (want != got) begin
            if (errors < 10)
              $display("mismatch: ang %h/%h lin %h/%h reached %b/%b (exp/act)",
                       want.ang, got.ang, want.lin, got.lin, want.reached, got.reached);
            errors <= errors + 1;
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready)
        cmd_queue.insert(cmd_queue.size(), steer(s_axis_tdata));
      if (cfg_valid && cfg_ready) begin
        case (ptp_pkg::reg_idx_t'(cfg_index))
          ptp_pkg::REG_GOAL_X:   goal_x <= longint'($signed(cfg_data));
          ptp_pkg::REG_GOAL_Y:   goal_y <= longint'($signed(cfg_data));
          ptp_pkg::REG_PLAN_RDY: plan_rdy <= cfg_data[0];
          ptp_pkg::REG_ANG_TOL:  ang_tol <= cfg_data[14:0];
          ptp_pkg::REG_POS_TOL:  pos_tol <= cfg_data[30:0];
          ptp_pkg::REG_ROT_THR:  rot_thr <= cfg_data[14:0];
          default: ;
        endcase
      end
    end
  end
endmodule

>>> tb/point_to_point_steering_controller_test.sv
// Top of the steering controller testbench: clock, reset, stimulus and verdict.
module point_to_point_steering_controller_test;
  timeunit 1ns;
  timeprecision 1ps;

  logic         clk, rst;
  logic         s_axis_tvalid, s_axis_tready;
  logic [127:0] s_axis_tdata;
  logic         m_axis_tvalid, m_axis_tready;
  logic [47:0]  m_axis_tdata;
  logic         m_axis_tuser;
  logic         cfg_valid, cfg_ready;
  logic [2:0]   cfg_index;
  logic [31:0]  cfg_data;
  int           errors, pending, commands_seen;
  int           poses_sent;

  point_to_point_steering_controller uut (.*);
  point_to_point_steering_controller_checker chk (.*);

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #50ms;
    $display("timeout");
    $display("FAIL");
    $finish;
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(5, 40);
  endfunction

  // random output stall
  initial begin
    m_axis_tready = 1'b0;
    @(negedge clk);
    forever begin
      m_axis_tready = 1'b1;
      repeat ($urandom_range(1, 30)) @(negedge clk);
      if ($urandom_range(0, 3) == 0) begin
        m_axis_tready = 1'b0;
        repeat (gap_len() + 1) @(negedge clk);
      end
    end
  end

  task automatic write_reg(ptp_pkg::reg_idx_t idx, logic [31:0] val);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic drain();
    s_axis_tvalid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (30) @(negedge clk);
  endtask

  task automatic send_pose(logic [31:0] px, py, logic [15:0] qx, qy, qz, qw, bit no_gap);
    s_axis_tvalid = 1'b1;
    s_axis_tdata = {qw, qz, qy, qx, py, px};
    do @(posedge clk); while (!s_axis_tready);
    poses_sent++;
    @(negedge clk);
    if (!no_gap) begin
      int g;
      g = gap_len();
      if (g > 0) begin
        s_axis_tvalid = 1'b0;
        repeat (g) @(negedge clk);
      end
    end
  endtask

  function automatic logic [15:0] rand_q();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 16'(16384);
    if (r == 1) return 16'(-16384);
    if (r == 2) return 16'h0;
    if (r == 3) return 16'($urandom);  // out of range, used as read
    return 16'($signed($urandom_range(0, 32768)) - 16384);
  endfunction

  function automatic logic [31:0] near(logic [31:0] base);
    int r;
    r = $urandom_range(0, 9);
    if (r < 5) return base + 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
    if (r < 7) return base + 32'($signed($urandom_range(0, 400)) - 200);
    if (r == 7) return base;
    return $urandom;
  endfunction

  initial begin
    logic [31:0] gx, gy;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    cfg_valid = 1'b0;
    cfg_index = ptp_pkg::REG_GOAL_X;
    cfg_data = '0;
    poses_sent = 0;
    rst = 1'b1;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // plan not ready at reset defaults
    send_pose(32'h0001_0000, 32'h0, 16'h0, 16'h0, 16'h0, 16'(16384), 0);
    send_pose(32'h8000_0000, 32'h7FFF_FFFF, 16'h7FFF, 16'h8000, 16'h0, 16'h0, 0);
    drain();

    write_reg(ptp_pkg::REG_PLAN_RDY, 32'd1);
    // at goal, zero quaternion, extremes, half turn, out-of-range quaternions
    send_pose(32'h0, 32'h0, 16'h0, 16'h0, 16'h0, 16'h0, 0);
    send_pose(32'h0, 32'h0, 16'h0, 16'h0, 16'h0, 16'(16384), 1);
    send_pose(32'h8000_0000, 32'h8000_0000, 16'(-16384), 16'(-16384), 16'(-16384),
              16'(-16384), 1);
    send_pose(32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'(16384), 16'(16384), 16'(16384),
              16'(16384), 0);
    send_pose(32'h0001_0000, 32'h0, 16'h0, 16'h0, 16'h0, 16'(16384), 0);
    send_pose(32'hFFFF_0000, 32'h0, 16'h0, 16'h0, 16'h0, 16'(16384), 0);
    send_pose(32'h0010_0000, 32'h0, 16'h0, 16'h0, 16'(16384), 16'h0, 0);
    send_pose(32'h0010_0000, 32'h1, 16'h0, 16'h0, 16'(16384), 16'h0, 0);
    send_pose(32'h0010_0000, 32'hFFFF_FFFF, 16'h0, 16'h0, 16'(16384), 16'h0, 0);
    send_pose(32'h0, 32'h0010_0000, 16'hFFFF, 16'h7FFF, 16'h8000, 16'h5555, 0);
    send_pose(32'hAAAA_AAAA, 32'h5555_5555, 16'hAAAA, 16'h5555, 16'hFFFF, 16'h8000, 0);
    drain();

    // register extremes
    write_reg(ptp_pkg::REG_GOAL_X, 32'h7FFF_FFFF);
    write_reg(ptp_pkg::REG_GOAL_Y, 32'h8000_0000);
    write_reg(ptp_pkg::REG_ANG_TOL, 32'd0);
    write_reg(ptp_pkg::REG_POS_TOL, 32'd0);
    write_reg(ptp_pkg::REG_ROT_THR, 32'd0);
    send_pose(32'h8000_0000, 32'h7FFF_FFFF, 16'h0, 16'h0, 16'h0, 16'(16384), 0);
    send_pose(32'h7FFF_FFFF, 32'h8000_0000, 16'h0, 16'h0, 16'h0, 16'(16384), 0);
    send_pose(32'h0, 32'h0, 16'(100), 16'(-200), 16'(300), 16'(16000), 0);
    drain();
    write_reg(ptp_pkg::REG_ANG_TOL, 32'd25736);
    write_reg(ptp_pkg::REG_POS_TOL, 32'h7FFF_FFFF);
    write_reg(ptp_pkg::REG_ROT_THR, 32'd25736);
    send_pose(32'h7FFF_FFFF, 32'h8000_0000, 16'h0, 16'h0, 16'h0, 16'(16384), 0);
    send_pose(32'h0, 32'h0, 16'(100), 16'(-200), 16'(300), 16'(16000), 0);
    send_pose(32'h8000_0000, 32'h7FFF_FFFF, 16'h0, 16'h0, 16'(16384), 16'h0, 0);
    drain();

    // random phases, registers changed between them
    for (int ph = 0; ph < 10; ph++) begin
      gx = (ph % 3 == 0) ? $urandom : 32'($signed($urandom_range(0, 1 << 24)) - (1 << 23));
      gy = (ph % 3 == 0) ? $urandom : 32'($signed($urandom_range(0, 1 << 24)) - (1 << 23));
      write_reg(ptp_pkg::REG_GOAL_X, gx);
      write_reg(ptp_pkg::REG_GOAL_Y, gy);
      write_reg(ptp_pkg::REG_PLAN_RDY, (ph == 4) ? 32'd0 : 32'd1);
      write_reg(ptp_pkg::REG_ANG_TOL, (ph == 1) ? 32'h7FFF : $urandom_range(0, 25736));
      write_reg(ptp_pkg::REG_POS_TOL, (ph == 2) ? $urandom : $urandom_range(0, 1 << 21));
      write_reg(ptp_pkg::REG_ROT_THR, (ph == 3) ? 32'h7FFF : $urandom_range(0, 25736));
      for (int k = 0; k < 150; k++)
        send_pose(near(gx), near(gy), rand_q(), rand_q(), rand_q(), rand_q(),
                  $urandom_range(0, 3) == 0);
      s_axis_tvalid = 1'b0;
      drain();
    end

    s_axis_tvalid = 1'b0;
    drain();
    $display("sent %0d pose items over directed and 10 random register settings", poses_sent);
    $display("checked %0d steering commands, %0d mismatches", commands_seen, errors);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule
